### rtl/spmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_pkg - shared widths, constants and types
// Most widths of the segment pair distance pipeline derive from the
// coordinate width below; QB, OUTW and LIMW are set on their own.
// ----------------------------------------------------------------------------
package spmd_pkg;

  // coordinate width (signed fixed point, 16 fraction bits)
  localparam int CW      = 32;
  // difference of two coordinates
  localparam int DW      = CW + 1;
  // dot product of two difference vectors (three terms)
  localparam int DOTW    = 2 * DW + 2;
  // wide multiplier operand, chunk count and chunk width
  localparam int MW      = DOTW;
  localparam int NCH     = 4;
  localparam int CH      = MW / NCH;
  localparam int PW      = 2 * MW;
  localparam int MUL_LAT = NCH;
  // clamped segment parameter: QB fraction bits, one extra bit for 1.0
  localparam int QB      = 32;
  localparam int QW      = QB + 1;
  localparam int DIV_LAT = QB + 1;
  localparam logic [QW-1:0] QONE = {1'b1, {QB{1'b0}}};
  // square root: drop the two parameter scales, then root bits
  localparam int SQ_SHIFT = 2 * QB;
  localparam int SQ_IN    = PW - SQ_SHIFT;
  localparam int RW       = SQ_IN / 2;
  localparam int SQ_LAT   = RW;
  localparam int OUTW     = 34;
  // degeneracy threshold register
  localparam int LIMW     = 16;
  localparam logic [LIMW-1:0] LIM_RST = LIMW'(1);

  typedef logic [2:0][DW-1:0] dvec_t;
  typedef logic [2:0][MW-1:0] wvec_t;

  typedef struct packed {
    dvec_t d1;
    dvec_t d2;
    dvec_t r;
  } geo_t;

  typedef struct packed {
    logic [MW-1:0] a;
    logic [MW-1:0] b;
    logic [MW-1:0] c;
    logic [MW-1:0] e;
    logic [MW-1:0] f;
    logic          adeg;
    logic          edeg;
    geo_t          g;
  } dots_t;

  typedef struct packed {
    dots_t         dt;
    logic [QW-1:0] s1;
  } dots_s_t;

  typedef struct packed {
    logic          tgt_t;
    logic [QW-1:0] s_fix;
    logic [QW-1:0] t_fix;
    geo_t          g;
  } pick_t;

endpackage
`default_nettype wire

### rtl/spmd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_mul - pipelined wide signed multiplier
// One operand chunk per stage is multiplied and accumulated.
// ----------------------------------------------------------------------------
module spmd_mul
  import spmd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [MW-1:0] in_a,
  input  wire logic [MW-1:0] in_b,
  output logic               out_vld,
  output logic [PW-1:0]      out_p
);

  localparam int PPW = MW + CH + 1;

  logic [MW-1:0] a_r   [NCH];
  logic [MW-1:0] b_r   [NCH];
  logic [PW-1:0] acc_r [NCH];
  logic          v_r   [NCH];

  for (genvar k = 0; k < NCH; k++) begin : g_stage
    logic [MW-1:0]        a_src;
    logic [MW-1:0]        b_src;
    logic [PW-1:0]        acc_src;
    logic                 v_src;
    logic signed [CH:0]   chunk;
    logic signed [PPW-1:0] pp;
    logic [PW-1:0]        pp_ext;

    if (k == 0) begin : g_first
      assign a_src   = in_a;
      assign b_src   = in_b;
      assign acc_src = '0;
      assign v_src   = in_vld;
    end else begin : g_next
      assign a_src   = a_r[k-1];
      assign b_src   = b_r[k-1];
      assign acc_src = acc_r[k-1];
      assign v_src   = v_r[k-1];
    end

    // top chunk carries the sign
    if (k == NCH - 1) begin : g_top
      assign chunk = {b_src[MW-1], b_src[CH*k +: CH]};
    end else begin : g_low
      assign chunk = {1'b0, b_src[CH*k +: CH]};
    end

    assign pp     = $signed(a_src) * chunk;
    assign pp_ext = {{(PW-PPW){pp[PPW-1]}}, pp};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k] <= acc_src + (pp_ext << (CH * k));
      end
    end

    if (k < NCH - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          a_r[k] <= a_src;
          b_r[k] <= b_src;
        end
      end
    end
  end

  assign out_vld = v_r[NCH-1];
  assign out_p   = acc_r[NCH-1];

endmodule
`default_nettype wire

### rtl/spmd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_div - pipelined clamped divider
// Returns num/den clamped to [0,1] in QB fraction bits, one bit per stage.
// ----------------------------------------------------------------------------
module spmd_div
  import spmd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [PW-1:0] in_num,
  input  wire logic [PW-1:0] in_den,
  output logic               out_vld,
  output logic [QW-1:0]      out_q
);

  logic [PW-1:0] rem_r [QB+1];
  logic [PW-1:0] den_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          fz_r  [QB+1];
  logic          fo_r  [QB+1];
  logic          v_r   [QB+1];

  logic nonpos;
  logic ge;

  assign nonpos = in_num[PW-1] || (in_num == '0);
  assign ge     = $signed(in_num) >= $signed(in_den);

  // entry stage: settle the clamped cases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_num;
      den_r[0] <= in_den;
      q_r[0]   <= '0;
      fz_r[0]  <= nonpos;
      fo_r[0]  <= !nonpos && ge;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [PW:0]   trial;
    logic [PW:0]   diff;
    logic          take;

    assign trial = {rem_r[i-1], 1'b0};
    assign diff  = trial - {1'b0, den_r[i-1]};
    assign take  = trial >= {1'b0, den_r[i-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i]  <= {q_r[i-1][QB-2:0], take};
        fz_r[i] <= fz_r[i-1];
        fo_r[i] <= fo_r[i-1];
      end
    end

    if (i < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= take ? diff[PW-1:0] : trial[PW-1:0];
          den_r[i] <= den_r[i-1];
        end
      end
    end
  end

  assign out_vld = v_r[QB];
  assign out_q   = fz_r[QB] ? '0 : (fo_r[QB] ? QONE : {1'b0, q_r[QB]});

endmodule
`default_nettype wire

### rtl/spmd_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_sqrt - pipelined integer square root
// Digit-by-digit restoring root, one result bit per stage, saturated output.
// ----------------------------------------------------------------------------
module spmd_sqrt
  import spmd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [SQ_IN-1:0] in_x,
  output logic                  out_vld,
  output logic [OUTW-1:0]       out_root
);

  localparam int RMW = RW + 2;

  logic [SQ_IN-1:0] x_r    [RW];
  logic [RMW-1:0]   rem_r  [RW];
  logic [RW-1:0]    root_r [RW];
  logic             v_r    [RW];

  for (genvar j = 0; j < RW; j++) begin : g_step
    logic [SQ_IN-1:0] x_src;
    logic [RMW-1:0]   rem_src;
    logic [RW-1:0]    root_src;
    logic             v_src;
    logic [RMW+1:0]   cur;
    logic [RMW+1:0]   trial;
    logic             take;

    if (j == 0) begin : g_first
      assign x_src    = in_x;
      assign rem_src  = '0;
      assign root_src = '0;
      assign v_src    = in_vld;
    end else begin : g_next
      assign x_src    = x_r[j-1];
      assign rem_src  = rem_r[j-1];
      assign root_src = root_r[j-1];
      assign v_src    = v_r[j-1];
    end

    assign cur   = {rem_src, x_src[SQ_IN-1-2*j -: 2]};
    assign trial = {2'b00, root_src, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= {root_src[RW-2:0], take};
      end
    end

    if (j < RW - 1) begin : g_carry
      logic [RMW+1:0] diff;
      assign diff = cur - trial;
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[j]   <= x_src;
          rem_r[j] <= take ? diff[RMW-1:0] : cur[RMW-1:0];
        end
      end
    end
  end

  assign out_vld  = v_r[RW-1];
  // clamp roots that do not fit the result width
  assign out_root = (|root_r[RW-1][RW-1:OUTW]) ? '1 : root_r[RW-1][OUTW-1:0];

endmodule
`default_nettype wire

### rtl/segment_pair_min_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_pair_min_distance - shortest distance between two 3D segments
// Clamped closest-parameter method, fully pipelined, one pair per cycle while no result is stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one word is a pair of segments, twelve signed Q15.16
//   endpoint coordinates, taken when in_valid is high and in_stall is low.
//   Output channel out_*: one word per input word, out_min_distance in
//   unsigned Q18.16, saturated at all ones, taken when out_valid is high and
//   out_stall is low.
//   cfg_we/cfg_wdata write degenerate_limit (squared length at or below
//   which a segment counts as a point); write it only while the block is idle.
// Throughput: one word per cycle while no result is stalled. The depth
//   comes from the two 33-stage clamped dividers, the 36-stage square root
//   and three levels of 4-stage wide multipliers.
// Reset: synchronous, active low; clears every stage valid bit and sets
//   degenerate_limit to 1.
// Stall: a stalled result freezes the whole pipeline; in_stall rises in the
//   same cycle, so no word is dropped or repeated. Bubbles flow while the
//   result register is empty or being taken.
// ----------------------------------------------------------------------------
module segment_pair_min_distance
  import spmd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  // configuration
  input  wire logic            cfg_we,
  input  wire logic [LIMW-1:0] cfg_wdata,
  // input words
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [CW-1:0]   in_seg_a_start_x,
  input  wire logic [CW-1:0]   in_seg_a_start_y,
  input  wire logic [CW-1:0]   in_seg_a_start_z,
  input  wire logic [CW-1:0]   in_seg_a_end_x,
  input  wire logic [CW-1:0]   in_seg_a_end_y,
  input  wire logic [CW-1:0]   in_seg_a_end_z,
  input  wire logic [CW-1:0]   in_seg_b_start_x,
  input  wire logic [CW-1:0]   in_seg_b_start_y,
  input  wire logic [CW-1:0]   in_seg_b_start_z,
  input  wire logic [CW-1:0]   in_seg_b_end_x,
  input  wire logic [CW-1:0]   in_seg_b_end_y,
  input  wire logic [CW-1:0]   in_seg_b_end_z,
  // result words
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [OUTW-1:0]      out_min_distance
);

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [DW-1:0] sdiff(input logic [CW-1:0] p, input logic [CW-1:0] q);
    logic signed [DW-1:0] ps;
    logic signed [DW-1:0] qs;
    ps = {p[CW-1], p};
    qs = {q[CW-1], q};
    return ps - qs;
  endfunction

  function automatic logic [2*DW-1:0] smul(input logic [DW-1:0] x, input logic [DW-1:0] y);
    logic signed [2*DW-1:0] xs;
    logic signed [2*DW-1:0] ys;
    xs = {{DW{x[DW-1]}}, x};
    ys = {{DW{y[DW-1]}}, y};
    return xs * ys;
  endfunction

  // parameter (0..1 scaled) times a difference component
  function automatic logic [MW-1:0] pmul(input logic [QW-1:0] q, input logic [DW-1:0] d);
    logic signed [MW-1:0] qs;
    logic signed [MW-1:0] ds;
    qs = {{(MW-QW){1'b0}}, q};
    ds = {{(MW-DW){d[DW-1]}}, d};
    return qs * ds;
  endfunction

  function automatic logic [MW-1:0] sum3(input logic [2:0][2*DW-1:0] v);
    logic [MW-1:0] acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc = acc + {{(MW-2*DW){v[k][2*DW-1]}}, v[k]};
    end
    return acc;
  endfunction

  function automatic logic [PW-1:0] wext(input logic [MW-1:0] v);
    return {{(PW-MW){v[MW-1]}}, v};
  endfunction

  // --------------------------------------------------------------------------
  // flow control: advance everything unless a held result is stalled
  // --------------------------------------------------------------------------
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic [LIMW-1:0] lim_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIM_RST;
    end else if (cfg_we) begin
      lim_r <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: direction vectors and start-to-start offset
  // --------------------------------------------------------------------------
  geo_t geo1_nxt, geo1_r;
  logic v1_r;

  always_comb begin
    geo1_nxt.d1[0] = sdiff(in_seg_a_end_x, in_seg_a_start_x);
    geo1_nxt.d1[1] = sdiff(in_seg_a_end_y, in_seg_a_start_y);
    geo1_nxt.d1[2] = sdiff(in_seg_a_end_z, in_seg_a_start_z);
    geo1_nxt.d2[0] = sdiff(in_seg_b_end_x, in_seg_b_start_x);
    geo1_nxt.d2[1] = sdiff(in_seg_b_end_y, in_seg_b_start_y);
    geo1_nxt.d2[2] = sdiff(in_seg_b_end_z, in_seg_b_start_z);
    geo1_nxt.r[0]  = sdiff(in_seg_b_start_x, in_seg_a_start_x);
    geo1_nxt.r[1]  = sdiff(in_seg_b_start_y, in_seg_a_start_y);
    geo1_nxt.r[2]  = sdiff(in_seg_b_start_z, in_seg_a_start_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo1_r <= geo1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: the fifteen component products of the five dot products
  // --------------------------------------------------------------------------
  logic [2:0][2*DW-1:0] paa_r, pee_r, pbb_r, pcc_r, pff_r;
  geo_t geo2_r;
  logic v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        paa_r[k] <= smul(geo1_r.d1[k], geo1_r.d1[k]);
        pee_r[k] <= smul(geo1_r.d2[k], geo1_r.d2[k]);
        pbb_r[k] <= smul(geo1_r.d1[k], geo1_r.d2[k]);
        pcc_r[k] <= smul(geo1_r.d1[k], geo1_r.r[k]);
        pff_r[k] <= smul(geo1_r.d2[k], geo1_r.r[k]);
      end
      geo2_r <= geo1_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: dot products and point tests
  // --------------------------------------------------------------------------
  dots_t dots3_nxt, dots3_r;
  logic  v3_r;
  logic [MW-1:0] lim_ext;

  assign lim_ext = {{(MW-LIMW){1'b0}}, lim_r};

  always_comb begin
    dots3_nxt.a    = sum3(paa_r);
    dots3_nxt.e    = sum3(pee_r);
    dots3_nxt.b    = sum3(pbb_r);
    dots3_nxt.c    = sum3(pcc_r);
    dots3_nxt.f    = sum3(pff_r);
    dots3_nxt.adeg = $signed(dots3_nxt.a) <= $signed(lim_ext);
    dots3_nxt.edeg = $signed(dots3_nxt.e) <= $signed(lim_ext);
    dots3_nxt.g    = geo2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dots3_r <= dots3_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // wide products for denominator and numerator of s
  // --------------------------------------------------------------------------
  logic [PW-1:0] p_ae, p_bb, p_bf, p_ce;
  logic          m1_vld;
  dots_t         dlm1_r [MUL_LAT];

  spmd_mul u_mul_ae (
    .clk, .rst_n, .en(adv), .in_vld(v3_r), .in_a(dots3_r.a), .in_b(dots3_r.e),
    .out_vld(m1_vld), .out_p(p_ae)
  );
  spmd_mul u_mul_bb (
    .clk, .rst_n, .en(adv), .in_vld(v3_r), .in_a(dots3_r.b), .in_b(dots3_r.b),
    .out_vld(), .out_p(p_bb)
  );
  spmd_mul u_mul_bf (
    .clk, .rst_n, .en(adv), .in_vld(v3_r), .in_a(dots3_r.b), .in_b(dots3_r.f),
    .out_vld(), .out_p(p_bf)
  );
  spmd_mul u_mul_ce (
    .clk, .rst_n, .en(adv), .in_vld(v3_r), .in_a(dots3_r.c), .in_b(dots3_r.e),
    .out_vld(), .out_p(p_ce)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dlm1_r[0] <= dots3_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        dlm1_r[i] <= dlm1_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: operands of the first division; a parallel pair or any
  // point case drops the numerator so s comes out zero
  // --------------------------------------------------------------------------
  logic [PW-1:0] denom, num1_nxt;
  logic [PW-1:0] num1_r, den1_r;
  dots_t         dots4_r;
  logic          v4_r;

  always_comb begin
    denom    = p_ae - p_bb;
    num1_nxt = p_bf - p_ce;
    if (dlm1_r[MUL_LAT-1].adeg || dlm1_r[MUL_LAT-1].edeg ||
        denom[PW-1] || (denom == '0)) begin
      num1_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num1_r  <= num1_nxt;
      den1_r  <= denom;
      dots4_r <= dlm1_r[MUL_LAT-1];
    end
  end

  // --------------------------------------------------------------------------
  // first clamped division: s on the first segment
  // --------------------------------------------------------------------------
  logic [QW-1:0] s1_q;
  logic          d1_vld;
  dots_t         dld1_r [DIV_LAT];

  spmd_div u_div_s (
    .clk, .rst_n, .en(adv), .in_vld(v4_r), .in_num(num1_r), .in_den(den1_r),
    .out_vld(d1_vld), .out_q(s1_q)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dld1_r[0] <= dots4_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dld1_r[i] <= dld1_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // b * s for the unclamped t numerator
  // --------------------------------------------------------------------------
  logic [PW-1:0] p_bs;
  logic          m2_vld;
  dots_s_t       dlm2_r [MUL_LAT];

  spmd_mul u_mul_bs (
    .clk, .rst_n, .en(adv), .in_vld(d1_vld), .in_a(dld1_r[DIV_LAT-1].b),
    .in_b({{(MW-QW){1'b0}}, s1_q}),
    .out_vld(m2_vld), .out_p(p_bs)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dlm2_r[0] <= '{dt: dld1_r[DIV_LAT-1], s1: s1_q};
      for (int i = 1; i < MUL_LAT; i++) begin
        dlm2_r[i] <= dlm2_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: pick the second division and which parameter it sets
  // --------------------------------------------------------------------------
  dots_s_t       ds6;
  logic [PW-1:0] tnum, esc;
  logic [PW-1:0] num2_nxt, den2_nxt;
  pick_t         pick6_nxt;
  logic [PW-1:0] num2_r, den2_r;
  pick_t         pick6_r;
  logic          v6_r;

  assign ds6 = dlm2_r[MUL_LAT-1];

  always_comb begin
    tnum = p_bs + (wext(ds6.dt.f) << QB);
    esc  = wext(ds6.dt.e) << QB;

    pick6_nxt.g     = ds6.dt.g;
    pick6_nxt.tgt_t = 1'b1;
    pick6_nxt.s_fix = '0;
    pick6_nxt.t_fix = '0;
    num2_nxt        = '0;
    den2_nxt        = PW'(1);

    if (ds6.dt.adeg && ds6.dt.edeg) begin
      // both points: s = t = 0 (zero numerator)
      pick6_nxt.tgt_t = 1'b1;
    end else if (ds6.dt.adeg) begin
      num2_nxt = wext(ds6.dt.f);
      den2_nxt = wext(ds6.dt.e);
    end else if (ds6.dt.edeg) begin
      pick6_nxt.tgt_t = 1'b0;
      num2_nxt        = '0 - wext(ds6.dt.c);
      den2_nxt        = wext(ds6.dt.a);
    end else if ($signed(tnum) < 0) begin
      // t below zero: pin t, recompute s
      pick6_nxt.tgt_t = 1'b0;
      num2_nxt        = '0 - wext(ds6.dt.c);
      den2_nxt        = wext(ds6.dt.a);
    end else if ($signed(tnum) > $signed(esc)) begin
      // t above one: pin t, recompute s
      pick6_nxt.tgt_t = 1'b0;
      pick6_nxt.t_fix = QONE;
      num2_nxt        = wext(ds6.dt.b) - wext(ds6.dt.c);
      den2_nxt        = wext(ds6.dt.a);
    end else begin
      pick6_nxt.s_fix = ds6.s1;
      num2_nxt        = tnum;
      den2_nxt        = esc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num2_r  <= num2_nxt;
      den2_r  <= den2_nxt;
      pick6_r <= pick6_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // second clamped division
  // --------------------------------------------------------------------------
  logic [QW-1:0] q2;
  logic          d2_vld;
  pick_t         dld2_r [DIV_LAT];

  spmd_div u_div_2 (
    .clk, .rst_n, .en(adv), .in_vld(v6_r), .in_num(num2_r), .in_den(den2_r),
    .out_vld(d2_vld), .out_q(q2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dld2_r[0] <= pick6_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dld2_r[i] <= dld2_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: final s, t and their products with the directions
  // --------------------------------------------------------------------------
  pick_t         pk7;
  logic [QW-1:0] s_fin, t_fin;
  wvec_t         tp_r, sp_r;
  dvec_t         r7_r;
  logic          v7_r;

  assign pk7   = dld2_r[DIV_LAT-1];
  assign s_fin = pk7.tgt_t ? pk7.s_fix : q2;
  assign t_fin = pk7.tgt_t ? q2 : pk7.t_fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        tp_r[k] <= pmul(t_fin, pk7.g.d2[k]);
        sp_r[k] <= pmul(s_fin, pk7.g.d1[k]);
      end
      r7_r <= pk7.g.r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: closest-point difference, scaled by 2^QB
  // --------------------------------------------------------------------------
  wvec_t dk_r;
  logic  v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (adv) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dk_r[k] <= ({{(MW-DW){r7_r[k][DW-1]}}, r7_r[k]} << QB) + tp_r[k] - sp_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // squares of the difference components
  // --------------------------------------------------------------------------
  logic [PW-1:0] sq0, sq1, sq2;
  logic          m3_vld;

  spmd_mul u_mul_sq0 (
    .clk, .rst_n, .en(adv), .in_vld(v8_r), .in_a(dk_r[0]), .in_b(dk_r[0]),
    .out_vld(m3_vld), .out_p(sq0)
  );
  spmd_mul u_mul_sq1 (
    .clk, .rst_n, .en(adv), .in_vld(v8_r), .in_a(dk_r[1]), .in_b(dk_r[1]),
    .out_vld(), .out_p(sq1)
  );
  spmd_mul u_mul_sq2 (
    .clk, .rst_n, .en(adv), .in_vld(v8_r), .in_a(dk_r[2]), .in_b(dk_r[2]),
    .out_vld(), .out_p(sq2)
  );

  // --------------------------------------------------------------------------
  // stage 9: squared distance, drop the two parameter scales
  // --------------------------------------------------------------------------
  logic [PW-1:0]    dist2;
  logic [SQ_IN-1:0] x9_r;
  logic             v9_r;

  assign dist2 = sq0 + sq1 + sq2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (adv) begin
      v9_r <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x9_r <= dist2[PW-1:SQ_SHIFT];
    end
  end

  // --------------------------------------------------------------------------
  // square root; its last stage is the result register
  // --------------------------------------------------------------------------
  spmd_sqrt u_sqrt (
    .clk, .rst_n, .en(adv), .in_vld(v9_r), .in_x(x9_r),
    .out_vld(out_valid), .out_root(out_min_distance)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_s_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    d1_vld |-> (s1_q <= QONE))
    else $error("first division result above one");

  a_den2_pos : assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> ($signed(den2_r) > 0))
    else $error("second division picked a non-positive denominator");

  a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && v9_r) |=> (v9_r && $stable(x9_r)))
    else $error("pipeline moved while the result was stalled");

endmodule
`default_nettype wire
